>>> sv/nested_tlv_message_writer_macros.svh
// ----------------------------------------------------------------------------
// nested_tlv_message_writer_macros
// assertion macros used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef NESTED_TLV_MESSAGE_WRITER_MACROS_SVH
`define NESTED_TLV_MESSAGE_WRITER_MACROS_SVH

// same-cycle implication, disabled in reset
`define NTLVW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define NTLVW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ntlvw_pkg.sv
// ----------------------------------------------------------------------------
// ntlvw_pkg
// types, constants and helpers for the nested tlv message writer
// ----------------------------------------------------------------------------
package ntlvw_pkg;

  localparam int MAX_DEPTH  = 8;
  localparam int DEPTH_W    = $clog2(MAX_DEPTH);
  localparam int BUF_BYTES  = 1024;
  localparam int POS_W      = 11;
  localparam int ADDR_W     = 10;
  localparam int CMD_W      = 4;
  localparam int CNT_W      = 4;
  localparam int BSIZE_W    = 11;
  localparam int HEAD_BYTES = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH1      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH2      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH3      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH4      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH8      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_NEST       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_UNNEST     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_UNNEST_ALL = 4'd7;
  localparam logic [CMD_W-1:0] CMD_START      = 4'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_DEEP    = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_PUSH,
    MODE_NEST,
    MODE_PATCH
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic close_step;
    logic emit_step;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_close;
    logic close_last;
    logic slot_free;
    logic emit_last;
  } dp_stat_t;

  // value bytes carried by a push code
  function automatic logic [CNT_W-1:0] push_len(input logic [CMD_W-1:0] c);
    logic [CNT_W-1:0] n;
    case (c)
      CMD_PUSH1: n = 4'd1;
      CMD_PUSH2: n = 4'd2;
      CMD_PUSH3: n = 4'd3;
      CMD_PUSH4: n = 4'd4;
      default:   n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

>>> sv/ntlvw_ifs.sv
// ----------------------------------------------------------------------------
// ntlvw_ifs
// valid/ready channels for commands and byte-write results
// ----------------------------------------------------------------------------
interface ntlvw_in_if import ntlvw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [7:0]       tag;
  logic [63:0]      value;

  modport source (output valid, cmd, tag, value, input ready);
  modport sink   (input valid, cmd, tag, value, output ready);
endinterface

interface ntlvw_out_if import ntlvw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              wr_valid;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_byte;
  logic [1:0]        status;
  logic [POS_W-1:0]  used_bytes;
  logic              last;

  modport source (output valid, wr_valid, wr_addr, wr_byte, status, used_bytes, last,
                  input ready);
  modport sink   (input valid, wr_valid, wr_addr, wr_byte, status, used_bytes, last,
                  output ready);
endinterface

>>> sv/ntlvw_ctrl.sv
// ----------------------------------------------------------------------------
// ntlvw_ctrl
// sequencer: accept, close levels, emit result beats
// ----------------------------------------------------------------------------
module ntlvw_ctrl import ntlvw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.need_close ? S_CLOSE : S_EMIT;
        end
      end
      S_CLOSE: begin
        cmd.close_step = 1'b1;
        if (stat.close_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_step = 1'b1;
          if (stat.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/ntlvw_dp.sv
// ----------------------------------------------------------------------------
// ntlvw_dp
// level stack, patch buffer, byte sequencing and result register
// ----------------------------------------------------------------------------
module ntlvw_dp import ntlvw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  input  logic [BSIZE_W-1:0] buf_cap,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [7:0]         in_tag,
  input  logic [63:0]        in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_wr_valid,
  output logic [ADDR_W-1:0]  out_wr_addr,
  output logic [7:0]         out_wr_byte,
  output logic [1:0]         out_status,
  output logic [POS_W-1:0]   out_used_bytes,
  output logic               out_last
);

  // level state
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [POS_W-1:0]   cur_r, cur_nxt;
  logic [POS_W-1:0]   stack_r [MAX_DEPTH];

  // per-command state
  mode_t              mode_r;
  logic [1:0]         st_r;
  logic [POS_W-1:0]   base_r;
  logic [7:0]         tag_r;
  logic [63:0]        val_r;
  logic [CNT_W-1:0]   len_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   idx_r;
  logic               single_r;

  // patch buffer, one entry per closed level
  logic [ADDR_W-1:0]  pa_addr_r [MAX_DEPTH];
  logic [7:0]         pa_byte_r [MAX_DEPTH];
  logic [1:0]         pa_st_r   [MAX_DEPTH];

  // result register
  logic               ov_r;
  logic               owv_r;
  logic [ADDR_W-1:0]  oaddr_r;
  logic [7:0]         obyte_r;
  logic [1:0]         ost_r;
  logic [POS_W-1:0]   oused_r;
  logic               olast_r;

  logic [POS_W:0]     lim;
  logic [POS_W:0]     push_end;
  logic [POS_W:0]     nest_end;
  logic [CNT_W-1:0]   in_len;
  logic               is_push;
  logic               is_close;

  logic [POS_W-1:0]   parent;
  logic [POS_W:0]     parent_hd;
  logic [POS_W-1:0]   contents;
  logic [POS_W-1:0]   patch_sum;

  logic               e_wv;
  logic [ADDR_W-1:0]  e_addr;
  logic [7:0]         e_byte;
  logic [1:0]         e_st;
  logic [POS_W-1:0]   e_sum;
  logic               e_last;
  logic [DEPTH_W-1:0] pidx;

  // room checks in one extra bit
  assign lim      = (buf_cap > BSIZE_W'(BUF_BYTES)) ? (POS_W+1)'(BUF_BYTES)
                                                     : (POS_W+1)'(buf_cap);
  assign in_len   = push_len(in_cmd);
  assign push_end = {1'b0, cur_r} + (POS_W+1)'(HEAD_BYTES) + (POS_W+1)'(in_len);
  assign nest_end = {1'b0, cur_r} + (POS_W+1)'(HEAD_BYTES);
  assign is_push  = (in_cmd <= CMD_PUSH8);
  assign is_close = (in_cmd == CMD_UNNEST) || (in_cmd == CMD_UNNEST_ALL);

  // closing one level
  assign parent    = stack_r[depth_r - DEPTH_W'(1)];
  assign parent_hd = {1'b0, parent} + (POS_W+1)'(HEAD_BYTES);
  assign contents  = ({1'b0, cur_r} >= parent_hd) ? POS_W'({1'b0, cur_r} - parent_hd)
                                                   : '0;
  assign patch_sum = POS_W'(parent_hd) + contents;

  assign pidx   = idx_r[DEPTH_W-1:0];
  assign e_sum  = base_r + POS_W'(idx_r);
  assign e_last = (idx_r == n_r - CNT_W'(1));

  always_comb begin
    e_wv   = 1'b1;
    e_addr = e_sum[ADDR_W-1:0];
    e_byte = '0;
    e_st   = ST_OK;
    case (mode_r)
      MODE_PUSH: begin
        if (idx_r == '0)              e_byte = tag_r;
        else if (idx_r == CNT_W'(1))  e_byte = 8'(len_r);
        else                          e_byte = val_r[63:56];
      end
      MODE_NEST: begin
        if (idx_r == '0) e_byte = tag_r;
      end
      MODE_PATCH: begin
        e_addr = pa_addr_r[pidx];
        e_byte = pa_byte_r[pidx];
        e_st   = pa_st_r[pidx];
      end
      default: begin
        e_wv   = 1'b0;
        e_addr = '0;
        e_st   = st_r;
      end
    endcase
  end

  assign stat.need_close = is_close && (depth_r != '0);
  assign stat.close_last = single_r || (depth_r == DEPTH_W'(1));
  assign stat.slot_free  = !ov_r || out_ready;
  assign stat.emit_last  = e_last;

  always_comb begin
    depth_nxt = depth_r;
    cur_nxt   = cur_r;
    if (cmd.load) begin
      if (is_push) begin
        if (push_end <= lim) cur_nxt = POS_W'(push_end);
      end else if (in_cmd == CMD_NEST) begin
        if ((depth_r != DEPTH_W'(MAX_DEPTH - 1)) && (nest_end <= lim)) begin
          cur_nxt   = POS_W'(nest_end);
          depth_nxt = depth_r + DEPTH_W'(1);
        end
      end else if (in_cmd == CMD_START) begin
        cur_nxt   = '0;
        depth_nxt = '0;
      end
    end else if (cmd.close_step) begin
      cur_nxt   = patch_sum;
      depth_nxt = depth_r - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      cur_r   <= cur_nxt;
      if (cmd.emit_step)  ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r    <= in_tag;
      len_r    <= in_len;
      base_r   <= cur_r;
      idx_r    <= '0;
      single_r <= (in_cmd == CMD_UNNEST);
      mode_r   <= MODE_NONE;
      st_r     <= ST_OK;
      n_r      <= CNT_W'(1);
      case (in_cmd)
        CMD_PUSH1: val_r <= in_value << 56;
        CMD_PUSH2: val_r <= in_value << 48;
        CMD_PUSH3: val_r <= in_value << 40;
        CMD_PUSH4: val_r <= in_value << 32;
        default:   val_r <= in_value;
      endcase
      if (is_push) begin
        if (push_end > lim) begin
          st_r <= ST_NO_ROOM;
        end else begin
          mode_r <= MODE_PUSH;
          n_r    <= CNT_W'(HEAD_BYTES) + in_len;
        end
      end else if (in_cmd == CMD_NEST) begin
        if (depth_r == DEPTH_W'(MAX_DEPTH - 1)) begin
          st_r <= ST_DEEP;
        end else if (nest_end > lim) begin
          st_r <= ST_NO_ROOM;
        end else begin
          mode_r           <= MODE_NEST;
          n_r              <= CNT_W'(HEAD_BYTES);
          stack_r[depth_r] <= cur_r;
        end
      end else if (is_close && (depth_r != '0)) begin
        mode_r <= MODE_PATCH;
        n_r    <= '0;
      end
    end
    if (cmd.close_step) begin
      pa_addr_r[n_r[DEPTH_W-1:0]] <= ADDR_W'(parent + POS_W'(1));
      pa_byte_r[n_r[DEPTH_W-1:0]] <= contents[7:0];
      pa_st_r[n_r[DEPTH_W-1:0]]   <= (contents > POS_W'(255)) ? ST_LONG : ST_OK;
      n_r <= n_r + CNT_W'(1);
    end
    if (cmd.emit_step) begin
      owv_r   <= e_wv;
      oaddr_r <= e_addr;
      obyte_r <= e_byte;
      ost_r   <= e_st;
      oused_r <= cur_r;
      olast_r <= e_last;
      idx_r   <= idx_r + CNT_W'(1);
      if ((mode_r == MODE_PUSH) && (idx_r >= CNT_W'(HEAD_BYTES))) val_r <= val_r << 8;
    end
  end

  assign out_valid      = ov_r;
  assign out_wr_valid   = owv_r;
  assign out_wr_addr    = oaddr_r;
  assign out_wr_byte    = obyte_r;
  assign out_status     = ost_r;
  assign out_used_bytes = oused_r;
  assign out_last       = olast_r;

endmodule

>>> sv/nested_tlv_message_writer.sv
// a command's first result beat passes the sequencer state register and then the
// result register before it shows on out_ch; an unnest first closes its levels
// push, nest and single-result commands go straight from accept to emitting beats
// unnest of k levels: one level closed per cycle then one patch beat per cycle
// unless out_ch stalls; the shared result register paces one buffer byte per cycle
// reset (synchronous, rst_n low): depth and write position cleared, buffer capacity 1024
// ----------------------------------------------------------------------------
// nested_tlv_message_writer
// builds nested tag-length-value messages as a stream of buffer byte writes
// ----------------------------------------------------------------------------
module nested_tlv_message_writer import ntlvw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  ntlvw_in_if.sink           in_ch,
  ntlvw_out_if.source        out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register index 0 sits at byte address 0, anything from 4 up is unmapped
  localparam logic REG_BUF_CAP = 1'b0;

  logic [BSIZE_W-1:0] buf_cap_r;
  logic               cfg_wr;
  ctl_cmd_t           cmd;
  dp_stat_t           stat;

  // apb: no wait states, write lands in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUF_CAP);
  assign prdata = (paddr[2] == REG_BUF_CAP) ? 32'(buf_cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cap_r <= BSIZE_W'(1024);
    end else if (cfg_wr) begin
      buf_cap_r <= pwdata[BSIZE_W-1:0];
    end
  end

  // sequencer: one command at a time, the datapath does all the arithmetic
  ntlvw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // level stack, patch buffer and the result beat register
  ntlvw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .buf_cap        (buf_cap_r),
    .in_cmd         (in_ch.cmd),
    .in_tag         (in_ch.tag),
    .in_value       (in_ch.value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_wr_valid   (out_ch.wr_valid),
    .out_wr_addr    (out_ch.wr_addr),
    .out_wr_byte    (out_ch.wr_byte),
    .out_status     (out_ch.status),
    .out_used_bytes (out_ch.used_bytes),
    .out_last       (out_ch.last)
  );

endmodule

>>> sv/ntlvw_checker.sv
// ----------------------------------------------------------------------------
// ntlvw_checker
// port-level checks of the tlv writer, bound to the top level
// ----------------------------------------------------------------------------
`include "nested_tlv_message_writer_macros.svh"

module ntlvw_checker import ntlvw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              wr_valid,
  input logic [ADDR_W-1:0] wr_addr,
  input logic [7:0]        wr_byte,
  input logic [1:0]        status,
  input logic [POS_W-1:0]  used_bytes,
  input logic              last
);

  // a stalled result beat holds
  `NTLVW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({wr_valid, wr_addr, wr_byte, status, used_bytes, last}), "result beat changed under stall")

  // every command yields at least one beat, so no back-to-back accept
  `NTLVW_ASSERT_NXT(a_one_cmd, clk, rst_n, in_valid && in_ready, !in_ready, "command accepted while previous one still in work")

  // a beat without a write carries a zero address and byte
  `NTLVW_ASSERT_NOW(a_no_wr_zero, clk, rst_n, out_valid && !wr_valid, (wr_addr == '0) && (wr_byte == '0), "idle beat carries address or data")

  // a beat without a write is always the only beat of its command
  `NTLVW_ASSERT_NOW(a_no_wr_last, clk, rst_n, out_valid && !wr_valid, last, "idle beat not marked last")

endmodule

bind nested_tlv_message_writer ntlvw_checker u_ntlvw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .wr_valid   (out_ch.wr_valid),
  .wr_addr    (out_ch.wr_addr),
  .wr_byte    (out_ch.wr_byte),
  .status     (out_ch.status),
  .used_bytes (out_ch.used_bytes),
  .last       (out_ch.last)
);

>>> tb/ntlvw_write_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntlvw_write_checker
// snoops the command, result and config ports, predicts every buffer write
// beat of the tlv writer and compares each result beat field by field
// ----------------------------------------------------------------------------
module ntlvw_write_checker import ntlvw_pkg::*; #(
  parameter logic [2:0] CFG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  ntlvw_in_if         in_mon,
  ntlvw_out_if        out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          beats_pending
);

  typedef struct packed {
    logic              wr_valid;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_byte;
    logic [1:0]        status;
    logic [POS_W-1:0]  used_bytes;
    logic              last;
  } wr_beat_t;

  wr_beat_t           expected_writes[$];
  wr_beat_t           cmd_writes[$];
  logic [BSIZE_W-1:0] buf_size = 11'(BUF_BYTES);
  int unsigned        depth = 0;
  int unsigned        level_pos[MAX_DEPTH];
  int                 errors = 0;
  int                 beat_count = 0;

  assign fail_count = errors;

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // one write beat of the current command; used_bytes and last are filled at the end
  task automatic stage(logic v, int unsigned addr, logic [7:0] data, logic [1:0] st);
    wr_beat_t w;
    w.wr_valid   = v;
    w.wr_addr    = v ? addr[ADDR_W-1:0] : '0;
    w.wr_byte    = v ? data : '0;
    w.status     = st;
    w.used_bytes = '0;
    w.last       = 1'b0;
    cmd_writes.push_back(w);
  endtask

  // close the innermost level and patch its length byte
  task automatic close_level();
    int unsigned parent, inner, contents;
    parent   = level_pos[depth-1];
    inner    = level_pos[depth];
    contents = (inner >= parent + HEAD_BYTES) ? inner - parent - HEAD_BYTES : 0;
    stage(1'b1, parent + 1, 8'(contents), (contents > 255) ? ST_LONG : ST_OK);
    level_pos[depth-1] = parent + HEAD_BYTES + contents;
    depth = depth - 1;
  endtask

  task automatic predict_writes(logic [CMD_W-1:0] cmd, logic [7:0] tag, logic [63:0] value);
    int unsigned pos, lim, len;
    wr_beat_t    w;
    pos = level_pos[depth];
    lim = (buf_size > BUF_BYTES) ? BUF_BYTES : buf_size;
    cmd_writes.delete();
    case (cmd)
      CMD_PUSH1, CMD_PUSH2, CMD_PUSH3, CMD_PUSH4, CMD_PUSH8: begin
        case (cmd)
          CMD_PUSH1: len = 1;
          CMD_PUSH2: len = 2;
          CMD_PUSH3: len = 3;
          CMD_PUSH4: len = 4;
          default:   len = 8;
        endcase
        if (pos + HEAD_BYTES + len > lim) begin
          stage(1'b0, 0, 8'd0, ST_NO_ROOM);
        end else begin
          stage(1'b1, pos, tag, ST_OK);
          stage(1'b1, pos + 1, 8'(len), ST_OK);
          // value bytes go out most significant first
          for (int i = 0; i < len; i++)
            stage(1'b1, pos + HEAD_BYTES + i, 8'(value >> (8 * (len - 1 - i))), ST_OK);
          level_pos[depth] = pos + HEAD_BYTES + len;
        end
      end
      CMD_NEST: begin
        if (depth + 1 >= MAX_DEPTH) begin
          stage(1'b0, 0, 8'd0, ST_DEEP);
        end else if (pos + HEAD_BYTES > lim) begin
          stage(1'b0, 0, 8'd0, ST_NO_ROOM);
        end else begin
          stage(1'b1, pos, tag, ST_OK);
          stage(1'b1, pos + 1, 8'd0, ST_OK);
          level_pos[depth+1] = pos + HEAD_BYTES;
          depth = depth + 1;
        end
      end
      CMD_UNNEST: begin
        if (depth == 0) stage(1'b0, 0, 8'd0, ST_OK);
        else close_level();
      end
      CMD_UNNEST_ALL: begin
        if (depth == 0) stage(1'b0, 0, 8'd0, ST_OK);
        else while (depth != 0) close_level();
      end
      CMD_START: begin
        depth = 0;
        foreach (level_pos[k]) level_pos[k] = 0;
        stage(1'b0, 0, 8'd0, ST_OK);
      end
      default: stage(1'b0, 0, 8'd0, ST_OK);
    endcase
    foreach (cmd_writes[k]) begin
      w            = cmd_writes[k];
      w.used_bytes = POS_W'(level_pos[depth]);
      w.last       = (k == cmd_writes.size() - 1);
      expected_writes.push_back(w);
    end
  endtask

  task automatic check_beat();
    wr_beat_t want;
    beat_count++;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
      return;
    end
    want = expected_writes.pop_front();
    if (out_mon.wr_valid !== want.wr_valid)
      report_mismatch($sformatf("beat %0d wr_valid %0h want %0h", beat_count,
                                out_mon.wr_valid, want.wr_valid));
    if (out_mon.wr_addr !== want.wr_addr)
      report_mismatch($sformatf("beat %0d wr_addr %0h want %0h", beat_count,
                                out_mon.wr_addr, want.wr_addr));
    if (out_mon.wr_byte !== want.wr_byte)
      report_mismatch($sformatf("beat %0d wr_byte %0h want %0h", beat_count,
                                out_mon.wr_byte, want.wr_byte));
    if (out_mon.status !== want.status)
      report_mismatch($sformatf("beat %0d status %0h want %0h", beat_count,
                                out_mon.status, want.status));
    if (out_mon.used_bytes !== want.used_bytes)
      report_mismatch($sformatf("beat %0d used_bytes %0h want %0h", beat_count,
                                out_mon.used_bytes, want.used_bytes));
    if (out_mon.last !== want.last)
      report_mismatch($sformatf("beat %0d last %0h want %0h", beat_count,
                                out_mon.last, want.last));
  endtask

  initial foreach (level_pos[k]) level_pos[k] = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      buf_size = 11'(BUF_BYTES);
      depth    = 0;
      foreach (level_pos[k]) level_pos[k] = 0;
      expected_writes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CFG_ADDR)
        buf_size = pwdata[BSIZE_W-1:0];
      if (out_mon.valid && out_mon.ready) check_beat();
      if (in_mon.valid && in_mon.ready) predict_writes(in_mon.cmd, in_mon.tag, in_mon.value);
    end
    beats_pending <= expected_writes.size();
  end

endmodule

>>> tb/tb_nested_tlv_message_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nested_tlv_message_writer
// drives directed and random tlv commands with random gaps and stalls through
// several buffer sizes; the write checker predicts and compares every beat
// ----------------------------------------------------------------------------
module tb_nested_tlv_message_writer;
  import ntlvw_pkg::*;

  // register map: buffer capacity is register 0, address 4 holds nothing
  localparam logic [2:0] BUF_SIZE_ADDR = 3'd0;
  localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  localparam logic [CMD_W-1:0] PUSH_CODES[5] = '{CMD_PUSH1, CMD_PUSH2, CMD_PUSH3,
                                                 CMD_PUSH4, CMD_PUSH8};

  // random phases: sender idle and receiver stall percentages, buffer size
  localparam int PHASE_IDLE[4]  = '{0, 48, 0, 10};
  localparam int PHASE_STALL[4] = '{0, 0, 48, 10};
  localparam int PHASE_BUF[4]   = '{1024, 64, 300, 24};
  localparam int PHASE_ITEMS    = 12;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int idle_pct = 0;
  int stall_pct = 0;
  int cmds_sent = 0;
  int cycle_count = 0;
  int fail_count;
  int beats_pending;

  ntlvw_in_if  cmd_ch ();
  ntlvw_out_if wr_ch ();

  nested_tlv_message_writer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_ch),
    .out_ch  (wr_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ntlvw_write_checker #(.CFG_ADDR(BUF_SIZE_ADDR)) wr_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (cmd_ch),
    .out_mon       (wr_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .beats_pending (beats_pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    wr_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = '0;
    cmd_ch.tag   = '0;
    cmd_ch.value = '0;
    wr_ch.ready  = 1'b0;
  end

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // one command beat, with random idle cycles in front of it
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [7:0] tag, logic [63:0] value);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= cmd;
    cmd_ch.tag   <= tag;
    cmd_ch.value <= value;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    cmds_sent++;
  endtask

  // hold off the sender until every predicted beat has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
  endtask

  // apb write: setup phase then access phase, then back to idle, block must be idle
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // well-formed message: start, random body leaning toward deeper nesting, close
  task automatic send_message();
    int body, guess_depth, roll;
    guess_depth = 0;
    body = $urandom_range(14, 3);
    send_cmd(CMD_START, 8'($urandom), rand_value());
    for (int i = 0; i < body; i++) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        send_cmd(CMD_NEST, 8'($urandom), rand_value());
        if (guess_depth < MAX_DEPTH - 1) guess_depth++;
      end else if (roll < 40 && guess_depth > 0) begin
        send_cmd(CMD_UNNEST, 8'($urandom), rand_value());
        guess_depth--;
      end else begin
        send_cmd(PUSH_CODES[$urandom_range(4)], 8'($urandom), rand_value());
      end
    end
    if ($urandom_range(99) < 80) send_cmd(CMD_UNNEST_ALL, 8'($urandom), rand_value());
  endtask

  // mostly messages, some noise over all codes, some stray closes and nests
  task automatic send_random(int count);
    int target, roll;
    target = cmds_sent + count;
    while (cmds_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_message();
      end else if (roll < 85) begin
        send_cmd(CMD_W'($urandom_range(15)), 8'($urandom), rand_value());
      end else begin
        case ($urandom_range(2))
          0: send_cmd(CMD_UNNEST, 8'($urandom), rand_value());
          1: send_cmd(CMD_UNNEST_ALL, 8'($urandom), rand_value());
          default: send_cmd(CMD_NEST, 8'($urandom), rand_value());
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(BUF_SIZE_ADDR, 32'd1024);

    // directed: every push width with extreme tags and values
    send_cmd(CMD_START, 8'h00, 64'd0);
    send_cmd(CMD_PUSH1, 8'h00, 64'd0);
    send_cmd(CMD_PUSH2, 8'hFF, {64{1'b1}});
    send_cmd(CMD_PUSH3, 8'h5A, 64'h0123_4567_89AB_CDEF);
    send_cmd(CMD_PUSH4, 8'hA5, rand_value());
    send_cmd(CMD_PUSH8, 8'h3C, 64'h8000_0000_0000_0001);
    // nest to the deepest level, then one too deep
    for (int i = 0; i < MAX_DEPTH - 1; i++) send_cmd(CMD_NEST, 8'(8'h10 + i), rand_value());
    send_cmd(CMD_NEST, 8'hEE, rand_value());
    send_cmd(CMD_PUSH8, 8'h77, rand_value());
    send_cmd(CMD_UNNEST, 8'h00, 64'd0);
    send_cmd(CMD_UNNEST_ALL, 8'h00, 64'd0);
    // closes at top level write nothing
    send_cmd(CMD_UNNEST, 8'h00, 64'd0);
    send_cmd(CMD_UNNEST_ALL, 8'h00, 64'd0);
    // codes past start are ignored
    send_cmd(CMD_UNUSED_LO, 8'hFF, {64{1'b1}});
    send_cmd(CMD_UNUSED_HI, 8'h00, 64'd0);

    // smallest buffer: a nest just fits, nothing else does
    drain();
    write_reg(BUF_SIZE_ADDR, 32'd2);
    write_reg(UNMAPPED_ADDR, 32'd1024);
    send_cmd(CMD_START, 8'h00, 64'd0);
    send_cmd(CMD_PUSH1, 8'h11, rand_value());
    send_cmd(CMD_NEST, 8'h22, rand_value());
    send_cmd(CMD_PUSH1, 8'h33, rand_value());
    send_cmd(CMD_NEST, 8'h44, rand_value());
    send_cmd(CMD_UNNEST, 8'h00, 64'd0);
    send_cmd(CMD_START, 8'h00, 64'd0);

    // random phases, each at its own buffer size and idling mix
    for (int p = 0; p < 4; p++) begin
      drain();
      idle_pct  = PHASE_IDLE[p];
      stall_pct = PHASE_STALL[p];
      write_reg(BUF_SIZE_ADDR, 32'(PHASE_BUF[p]));
      send_random(PHASE_ITEMS);
    end

    // full buffer: one container filled to two bytes short of the end gives a length over 255,
    // then a last nest lands on the final two bytes
    drain();
    idle_pct  = 0;
    stall_pct = 48;
    write_reg(BUF_SIZE_ADDR, 32'd1024);
    send_cmd(CMD_START, 8'h00, 64'd0);
    send_cmd(CMD_NEST, 8'hC0, rand_value());
    for (int i = 0; i < (BUF_BYTES - 2) / 10; i++)
      send_cmd(CMD_PUSH8, 8'($urandom), rand_value());
    send_cmd(CMD_PUSH8, 8'hC1, rand_value());
    send_cmd(CMD_PUSH1, 8'hC2, rand_value());
    send_cmd(CMD_UNNEST, 8'h00, 64'd0);
    send_cmd(CMD_NEST, 8'hC3, rand_value());
    send_cmd(CMD_NEST, 8'hC4, rand_value());
    send_cmd(CMD_UNNEST_ALL, 8'h00, 64'd0);

    // wait out the tail, then give the verdict
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
